// ===== src/twrms_pkg.sv =====
// twrms_pkg: shared widths, register codes and queue item type for the
// three-channel windowed rms meter; no dependencies
package twrms_pkg;

    localparam int ADC_BITS      = 12;
    localparam int TICK_BITS     = 10;
    localparam int NCH           = 3;
    localparam int CH_BITS       = 2;
    localparam int SUM_BITS      = 2 * ADC_BITS + TICK_BITS;
    localparam int FRAC_BITS     = 16;
    localparam int RAD_BITS      = SUM_BITS + FRAC_BITS;
    localparam int ROOT_BITS     = RAD_BITS / 2;
    localparam int SREM_BITS     = ROOT_BITS + 1;
    localparam int GAIN_BITS     = 16;
    localparam int PROD_BITS     = ROOT_BITS + GAIN_BITS;
    localparam int RND_SHIFT     = 20;
    localparam int RMS_BITS      = 16;
    localparam int STEP_BITS     = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 2'd2;

    localparam logic [11:0]        OFFSET_RST = 12'd0;
    localparam logic [9:0]         WINDOW_RST = 10'd80;
    localparam logic [GAIN_BITS-1:0] GAIN_RST = 16'd4096;

    // one classified tick on its way to the back end
    typedef struct packed {
        logic                          emit;
        logic [NCH-1:0]                hit;
        logic [NCH-1:0][ADC_BITS-1:0]  samp;
    } cmd_t;

endpackage

// ===== src/three_channel_windowed_rms_top.sv =====
// three_channel_windowed_rms_top: configuration registers and the
// front / queue / back chain; depends on twrms_pkg and the twrms_* modules
//
// Usage:
//   Input channel (in_valid/in_ready, sample_r/y/b): one transfer per timer
//   tick carrying one raw sample per phase. Output channel (out_valid/
//   out_ready, rms_r/y/b): one transfer per window with the three rms values
//   in centivolts. cfg_we/cfg_index/cfg_data writes offset threshold, window
//   length and gain while the block is idle; the user must keep to this, the
//   block itself does not enforce it.
//   Window end: the tick passes the queue, then per channel load, divide,
//   square root, multiply and round steps (zero count gives zero at load),
//   then the output register load. Other ticks are accumulated on pop; one
//   tick per cycle is accepted while the two-entry queue has room.
//   Throughput: windows are bounded by the serial divide and square root
//   unit; the next window end waits until the last result is loaded.
//   Reset: sums, counts and tick counter clear; registers go to threshold 0,
//   window 80, gain 1.0.
//   Stall: a waiting result holds in the output register; ticks keep being
//   accumulated, and the next window end waits in the queue until the
//   engine and output register are free.
module three_channel_windowed_rms_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [twrms_pkg::ADC_BITS-1:0]      sample_r,
    input  logic [twrms_pkg::ADC_BITS-1:0]      sample_y,
    input  logic [twrms_pkg::ADC_BITS-1:0]      sample_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [twrms_pkg::RMS_BITS-1:0]      rms_r,
    output logic [twrms_pkg::RMS_BITS-1:0]      rms_y,
    output logic [twrms_pkg::RMS_BITS-1:0]      rms_b,
    input  logic                                cfg_we,
    input  logic [twrms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [twrms_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import twrms_pkg::*;

    logic [11:0]          offset_reg;
    logic [9:0]           window_reg;
    logic [GAIN_BITS-1:0] gain_reg;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_wdata;
    cmd_t q_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            window_reg <= WINDOW_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET: offset_reg <= cfg_data[11:0];
                CFG_WINDOW: window_reg <= cfg_data[9:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_BITS-1:0];
                default:    gain_reg   <= gain_reg;
            endcase
        end
    end

    twrms_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_r         (sample_r),
        .sample_y         (sample_y),
        .sample_b         (sample_b),
        .offset_threshold (offset_reg),
        .window_ticks     (window_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_wdata)
    );

    twrms_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    twrms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .gain_q412 (gain_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rms_r     (rms_r),
        .rms_y     (rms_y),
        .rms_b     (rms_b)
    );

endmodule

// ===== src/twrms_front.sv =====
// twrms_front: accepts ticks, keeps the tick counter and classifies each tick
// as accumulate or emit; depends on twrms_pkg
module twrms_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [twrms_pkg::ADC_BITS-1:0] sample_r,
    input  logic [twrms_pkg::ADC_BITS-1:0] sample_y,
    input  logic [twrms_pkg::ADC_BITS-1:0] sample_b,
    input  logic [11:0]                    offset_threshold,
    input  logic [9:0]                     window_ticks,
    input  logic                           q_full,
    output logic                           q_push,
    output twrms_pkg::cmd_t                q_data
);
    import twrms_pkg::*;

    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] tick_next;
    logic [TICK_BITS-1:0] win;
    logic                 emit;

    // window saturated to the counter range
    assign win  = (window_ticks > 10'(TICK_MAX)) ? TICK_MAX : TICK_BITS'(window_ticks);
    assign emit = (tick_reg >= win);

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // classify the tick
    always_comb
    begin
        q_data.emit    = emit;
        q_data.samp[0] = sample_r;
        q_data.samp[1] = sample_y;
        q_data.samp[2] = sample_b;
        q_data.hit[0]  = (sample_r > offset_threshold);
        q_data.hit[1]  = (sample_y > offset_threshold);
        q_data.hit[2]  = (sample_b > offset_threshold);
    end

    // tick counter
    always_comb
    begin
        tick_next = tick_reg;
        if (q_push)
        begin
            if (emit)
                tick_next = '0;
            else
                tick_next = tick_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= '0;
        else
            tick_reg <= tick_next;
    end

    // an emitting tick restarts the window
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && emit) |=> (tick_reg == '0))
        else $error("tick counter not cleared after emit");

endmodule

// ===== src/twrms_queue.sv =====
// twrms_queue: two-entry queue of classified ticks between front and back
// depends on twrms_pkg
module twrms_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  twrms_pkg::cmd_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output twrms_pkg::cmd_t rdata
);
    import twrms_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

endmodule

// ===== src/twrms_back.sv =====
// twrms_back: accumulates squares per channel and runs the serial divide,
// square root and gain scaling at window end; depends on twrms_pkg
module twrms_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  twrms_pkg::cmd_t                 q_data,
    output logic                            q_pop,
    input  logic [twrms_pkg::GAIN_BITS-1:0] gain_q412,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [twrms_pkg::RMS_BITS-1:0]  rms_r,
    output logic [twrms_pkg::RMS_BITS-1:0]  rms_y,
    output logic [twrms_pkg::RMS_BITS-1:0]  rms_b
);
    import twrms_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SUM_BITS - 1);
    localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(ROOT_BITS - 1);
    localparam logic [PROD_BITS:0]   RND_HALF  = (PROD_BITS+1)'(1) << (RND_SHIFT - 1);
    localparam logic [CH_BITS-1:0]   CH_LAST   = CH_BITS'(NCH - 1);

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [SUM_BITS-1:0]    acc_sum_reg [NCH];
    logic [TICK_BITS-1:0]   acc_cnt_reg [NCH];
    logic [SUM_BITS-1:0]    wsum_reg    [NCH];
    logic [TICK_BITS-1:0]   wcnt_reg    [NCH];
    logic [RMS_BITS-1:0]    res_reg     [NCH];
    logic [CH_BITS-1:0]     ch_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [TICK_BITS-1:0]   rem_reg;
    logic [RAD_BITS-1:0]    rad_reg;
    logic [SREM_BITS-1:0]   srem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   out_valid_reg;
    logic [RMS_BITS-1:0]    out_r_reg;
    logic [RMS_BITS-1:0]    out_y_reg;
    logic [RMS_BITS-1:0]    out_b_reg;

    logic                   pop_acc;
    logic                   pop_emit;
    logic                   out_load;
    logic [TICK_BITS-1:0]   den;
    logic [TICK_BITS:0]     div_trial;
    logic                   div_bit;
    logic [SUM_BITS-1:0]    quo_shift;
    logic [SREM_BITS+1:0]   sq_t;
    logic [SREM_BITS+1:0]   sq_trial;
    logic                   sq_bit;
    logic [PROD_BITS:0]     rnd_sum;
    logic [PROD_BITS-RND_SHIFT:0] rnd_val;
    logic [RMS_BITS-1:0]    rnd_sat;

    // queue pop: accumulate at once, emit only with the engine free
    assign q_pop    = q_valid && (!q_data.emit || (state_reg == ST_IDLE));
    assign pop_acc  = q_pop && !q_data.emit;
    assign pop_emit = q_pop && q_data.emit;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // divide step: one quotient bit a cycle
    assign den       = wcnt_reg[ch_reg];
    assign div_trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign div_bit   = (div_trial >= {1'b0, den});
    assign quo_shift = {quo_reg[SUM_BITS-2:0], div_bit};

    // square root step: one root bit a cycle
    assign sq_t     = {srem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign sq_trial = (SREM_BITS+2)'({root_reg, 2'b01});
    assign sq_bit   = (sq_t >= sq_trial);

    // round to whole centivolts and saturate
    assign rnd_sum = {1'b0, prod_reg} + RND_HALF;
    assign rnd_val = rnd_sum[PROD_BITS:RND_SHIFT];
    assign rnd_sat = (|rnd_val[PROD_BITS-RND_SHIFT:RMS_BITS]) ? {RMS_BITS{1'b1}}
                                                              : rnd_val[RMS_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (pop_emit)
                    state_next = ST_LOAD;
            ST_LOAD:
                if (den == '0)
                    state_next = (ch_reg == CH_LAST) ? ST_DONE : ST_LOAD;
                else
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == DIV_LAST)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (step_reg == SQRT_LAST)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_RND;
            ST_RND:
                state_next = (ch_reg == CH_LAST) ? ST_DONE : ST_LOAD;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                acc_sum_reg[i] <= '0;
                acc_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // accumulators
            if (pop_emit)
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    acc_sum_reg[i] <= '0;
                    acc_cnt_reg[i] <= '0;
                end
            end
            else if (pop_acc)
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    if (q_data.hit[i])
                    begin
                        acc_sum_reg[i] <= acc_sum_reg[i]
                            + SUM_BITS'(q_data.samp[i] * q_data.samp[i]);
                        acc_cnt_reg[i] <= acc_cnt_reg[i] + 1'b1;
                    end
                end
            end

            // channel and step counters
            case (state_reg)
                ST_IDLE:
                    ch_reg <= '0;
                ST_LOAD:
                begin
                    step_reg <= '0;
                    if (den == '0)
                        ch_reg <= ch_reg + 1'b1;
                end
                ST_DIV:
                    step_reg <= (step_reg == DIV_LAST) ? '0 : step_reg + 1'b1;
                ST_SQRT:
                    step_reg <= step_reg + 1'b1;
                ST_RND:
                    ch_reg <= ch_reg + 1'b1;
                default:
                    step_reg <= step_reg;
            endcase

            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop_emit)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                wsum_reg[i] <= acc_sum_reg[i];
                wcnt_reg[i] <= acc_cnt_reg[i];
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                quo_reg <= wsum_reg[ch_reg];
                rem_reg <= '0;
                if (den == '0)
                    res_reg[ch_reg] <= '0;
            end
            ST_DIV:
            begin
                quo_reg <= quo_shift;
                if (div_bit)
                    rem_reg <= TICK_BITS'(div_trial - {1'b0, den});
                else
                    rem_reg <= div_trial[TICK_BITS-1:0];
                if (step_reg == DIV_LAST)
                begin
                    rad_reg  <= {quo_shift, {FRAC_BITS{1'b0}}};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            ST_SQRT:
            begin
                rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_BITS-2:0], sq_bit};
                if (sq_bit)
                    srem_reg <= SREM_BITS'(sq_t - sq_trial);
                else
                    srem_reg <= SREM_BITS'(sq_t);
            end
            ST_MUL:
                prod_reg <= root_reg * gain_q412;
            ST_RND:
                res_reg[ch_reg] <= rnd_sat;
            default:
                prod_reg <= prod_reg;
        endcase

        if (out_load)
        begin
            out_r_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_b_reg <= res_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_r     = out_r_reg;
    assign rms_y     = out_y_reg;
    assign rms_b     = out_b_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den != '0))
        else $error("divide started with zero count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

// ===== tb/sv/three_channel_windowed_rms_top_test.sv =====
// three_channel_windowed_rms_top_test: self-checking bench for the windowed rms meter
// depends on twrms_pkg and three_channel_windowed_rms_top; a scoreboard class
// predicts each window result from the accepted ticks
module three_channel_windowed_rms_top_test;
    import twrms_pkg::*;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        logic [RMS_BITS-1:0] r;
        logic [RMS_BITS-1:0] y;
        logic [RMS_BITS-1:0] b;
    } rms_triple_t;

    // window accumulation model and store of expected rms triples
    class rms_scoreboard;
        logic [ADC_BITS-1:0]  threshold;
        logic [TICK_BITS-1:0] window;
        logic [GAIN_BITS-1:0] gain;
        logic [TICK_BITS-1:0] ticks;
        logic [SUM_BITS-1:0]  sums [NCH];
        logic [TICK_BITS-1:0] counts [NCH];
        rms_triple_t          rms_q [$];
        int                   errors;

        function new();
            threshold = OFFSET_RST;
            window    = WINDOW_RST;
            gain      = GAIN_RST;
            ticks     = '0;
            errors    = 0;
            for (int c = 0; c < NCH; c++)
            begin
                sums[c]   = '0;
                counts[c] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_OFFSET: threshold = data[ADC_BITS-1:0];
                CFG_WINDOW: window    = data[TICK_BITS-1:0];
                CFG_GAIN:   gain      = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // mean square, root in q.8, gain and rounding to centivolts
        function logic [RMS_BITS-1:0] channel_rms(logic [SUM_BITS-1:0] sum,
                                                  logic [TICK_BITS-1:0] n);
            longint unsigned x, root, probe, v;
            if (n == 0)
                return '0;
            x = (longint'(sum) / longint'(n)) << 16;
            root = 0;
            probe = 64'd1 << 62;
            while (probe > x)
                probe >>= 2;
            while (probe != 0)
            begin
                if (x >= root + probe)
                begin
                    x -= root + probe;
                    root = (root >> 1) + probe;
                end
                else
                    root >>= 1;
                probe >>= 2;
            end
            v = (root * gain + (64'd1 << 19)) >> 20;
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        // one accepted tick: either accumulate or close the window
        function void note_tick(logic [ADC_BITS-1:0] sr, logic [ADC_BITS-1:0] sy,
                                logic [ADC_BITS-1:0] sb);
            logic [ADC_BITS-1:0] s [NCH];
            rms_triple_t t;
            s[0] = sr; s[1] = sy; s[2] = sb;
            if (ticks >= window)
            begin
                t.r = channel_rms(sums[0], counts[0]);
                t.y = channel_rms(sums[1], counts[1]);
                t.b = channel_rms(sums[2], counts[2]);
                rms_q.push_back(t);
                for (int c = 0; c < NCH; c++)
                begin
                    sums[c]   = '0;
                    counts[c] = '0;
                end
                ticks = '0;
                return;
            end
            ticks = ticks + 1'b1;
            for (int c = 0; c < NCH; c++)
                if (s[c] > threshold)
                begin
                    sums[c]   = sums[c] + s[c] * s[c];
                    counts[c] = counts[c] + 1'b1;
                end
        endfunction

        function void check_result(logic [RMS_BITS-1:0] r, logic [RMS_BITS-1:0] y,
                                   logic [RMS_BITS-1:0] b);
            rms_triple_t t;
            if (rms_q.size() == 0)
            begin
                $error("rms transfer with nothing expected: %0d %0d %0d", r, y, b);
                errors++;
                return;
            end
            t = rms_q.pop_front();
            if (r !== t.r)
            begin
                $error("rms_r expected %0d actual %0d", t.r, r);
                errors++;
            end
            if (y !== t.y)
            begin
                $error("rms_y expected %0d actual %0d", t.y, y);
                errors++;
            end
            if (b !== t.b)
            begin
                $error("rms_b expected %0d actual %0d", t.b, b);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ADC_BITS-1:0]      sample_r;
    logic [ADC_BITS-1:0]      sample_y;
    logic [ADC_BITS-1:0]      sample_b;
    logic                     out_valid;
    logic                     out_ready;
    logic [RMS_BITS-1:0]      rms_r;
    logic [RMS_BITS-1:0]      rms_y;
    logic [RMS_BITS-1:0]      rms_b;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    rms_scoreboard sb;
    bit            send_burst;
    int            rms_seen;

    three_channel_windowed_rms_top DUT (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    initial
    begin
        #(12 * 3000000);
        $display("Some tests failed");
        $finish;
    end

    // one register write on a single cycle
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one tick transfer, valid kept high across back-to-back ticks
    task automatic send_tick(logic [ADC_BITS-1:0] sr, logic [ADC_BITS-1:0] sy,
                             logic [ADC_BITS-1:0] sbv);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_r <= sr;
        sample_y <= sy;
        sample_b <= sbv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(sr, sy, sbv);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.rms_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ADC_BITS-1:0] pick_sample(logic [ADC_BITS-1:0] thr);
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'hFFF;
            2: return thr;
            3: return thr + 1'b1;
            default: return ADC_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    // result side with random stalls and one long hold-off
    initial
    begin
        int stall;
        bit long_done;
        out_ready = 1'b0;
        rms_seen  = 0;
        long_done = 0;
        forever
        begin
            @(negedge clk);
            if (!long_done && rms_seen == 40)
            begin
                stall = 3000;
                long_done = 1;
            end
            else if (rms_seen % 64 < 16)
                stall = 0;
            else
                stall = $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(rms_r, rms_y, rms_b);
            rms_seen++;
        end
    end

    // stimulus
    initial
    begin
        logic [ADC_BITS-1:0] thr;
        logic [TICK_BITS-1:0] win;
        int n;
        sb = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_r   = '0;
        sample_y   = '0;
        sample_b   = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_OFFSET;
        cfg_data   = '0;
        send_burst = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: full scale samples with max gain, zero samples are not counted
        write_reg(CFG_WINDOW, 16'd3);
        write_reg(CFG_GAIN, 16'hFFFF);
        send_tick(12'hFFF, 12'hFFF, 12'hFFF);
        send_tick(12'hFFF, 12'h000, 12'h001);
        send_tick(12'hFFF, 12'h000, 12'h800);
        send_tick(12'h000, 12'h000, 12'h000);
        drain();
        // threshold at top: nothing accumulates
        write_reg(CFG_OFFSET, 16'hFFF);
        write_reg(CFG_GAIN, 16'd4096);
        repeat (4) send_tick(12'hFFF, 12'hFFE, 12'h000);
        drain();
        // samples equal to threshold are excluded, one above counts
        write_reg(CFG_OFFSET, 16'd100);
        write_reg(CFG_GAIN, 16'd0);
        write_reg(CFG_GAIN, 16'd12345);
        repeat (2) send_tick(12'd100, 12'd101, 12'd4095);
        drain();
        // unused index is ignored
        write_reg(CFG_UNUSED, 16'hFFFF);
        // lowered window mid-window emits on the next tick
        send_tick(12'd500, 12'd1000, 12'd2000);
        drain();
        write_reg(CFG_WINDOW, 16'd1);
        send_tick(12'd7, 12'd7, 12'd7);
        drain();
        // zero window: every tick emits zeros
        write_reg(CFG_WINDOW, 16'd0);
        repeat (3) send_tick(12'hABC, 12'h123, 12'hFFF);
        drain();

        // random phases with varied settings
        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 3))
                0: thr = 12'd0;
                1: thr = 12'hFFF;
                default: thr = ADC_BITS'($urandom_range(0, 4095));
            endcase
            write_reg(CFG_OFFSET, CFG_DATA_BITS'(thr));
            if (p == 9)
                win = 10'd1023;
            else if (p == 3)
                win = 10'd0;
            else if (p == 1)
                win = 10'd1;
            else
                win = TICK_BITS'($urandom_range(1, 20));
            write_reg(CFG_WINDOW, CFG_DATA_BITS'(win));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_GAIN, 16'hFFFF);
                1: write_reg(CFG_GAIN, 16'd0);
                default: write_reg(CFG_GAIN, CFG_DATA_BITS'($urandom_range(0, 65535)));
            endcase
            n = (p == 9) ? 1030 : 90;
            for (int i = 0; i < n; i++)
            begin
                if (i % 30 == 0)
                    send_burst = ($urandom_range(0, 2) == 0);
                send_tick(pick_sample(thr), pick_sample(thr), pick_sample(thr));
            end
            send_burst = 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
